// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by the datapath (lpt_dp).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define LPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Plain invariant, built on the implication form.
`define LPT_ASSERT_INV(lbl, clk, rst_n, expr) \
  `LPT_ASSERT_IMP(lbl, clk, rst_n, 1'b1, expr)

`endif

// ----- hw/rtl/lpt_pkg.sv -----
`timescale 1ns / 1ps
package lpt_pkg;

  typedef enum logic [1:0] {
    OP_RECORD    = 2'd0,
    OP_UPDATE    = 2'd1,
    OP_SUMMARIZE = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  localparam int unsigned PCT_MED   = 50;
  localparam int unsigned PCT_HI    = 95;
  localparam int unsigned PCT_SCALE = 100;

  typedef struct packed {
    logic rec;        // write a new sample at the write pointer
    logic upd;        // rewrite tag, queries, exceeded flag of newest entry
    logic start;      // latch workload, clear accumulators and counters
    logic rd_cand;    // read address from candidate counter, else walk counter
    logic acc_scan;   // first pass: count, max, exceeded
    logic acc_rank;   // inner pass: rank counts against candidate
    logic cand_latch; // capture candidate values, clear rank counts
    logic eval;       // test candidate against the two ranks
    logic j_clr;
    logic j_inc;
    logic i_inc;
    logic load_out;   // copy results into output registers
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic j_last;
    logic i_last;
    logic cand_match;
  } sts_t;

endpackage

// ----- hw/rtl/lpt_ctrl.sv -----
`timescale 1ns / 1ps
module lpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lpt_pkg::sts_t sts_i,
  output lpt_pkg::cmd_t cmd_o
);
  import lpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_CREQ, S_CCHK, S_INNER, S_INNER_W, S_EVAL, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_RECORD: cmd_o.rec = 1'b1;
            OP_UPDATE: cmd_o.upd = !sts_i.fill_zero;
            OP_SUMMARIZE: begin
              cmd_o.start = 1'b1;
              state_d = sts_i.fill_zero ? S_DONE : S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.acc_scan = 1'b1;
        cmd_o.j_inc    = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.j_clr = 1'b1;
          state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: state_d = S_CREQ;
      S_CREQ: begin
        cmd_o.rd_cand = 1'b1;
        state_d = S_CCHK;
      end
      S_CCHK: begin
        cmd_o.cand_latch = 1'b1;
        if (sts_i.cand_match) begin
          state_d = S_INNER;
        end else if (sts_i.i_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_CREQ;
        end
      end
      S_INNER: begin
        cmd_o.acc_rank = 1'b1;
        cmd_o.j_inc    = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.j_clr = 1'b1;
          state_d = S_INNER_W;
        end
      end
      S_INNER_W: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_CREQ;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/lpt_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpt_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lpt_pkg::cmd_t cmd_i,
  output lpt_pkg::sts_t sts_o,
  input  logic [63:0]   elapsed_ns_i,
  input  logic [3:0]    workload_i,
  input  logic [31:0]   query_count_i,
  input  logic          budget_exceeded_i,
  output logic [3:0]    summary_workload_o,
  output logic [6:0]    match_count_o,
  output logic [63:0]   time_p50_o,
  output logic [63:0]   time_p95_o,
  output logic [31:0]   queries_p50_o,
  output logic [31:0]   queries_p95_o,
  output logic [31:0]   queries_max_o,
  output logic [6:0]    exceeded_total_o
);
  import lpt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = CW + 7;

  logic [63:0] time_mem  [DEPTH];
  logic [3:0]  tag_mem   [DEPTH];
  logic [31:0] query_mem [DEPTH];
  logic        exc_mem   [DEPTH];

  logic [AW-1:0] wp_q, i_q, j_q, newest, rd_addr;
  logic [CW-1:0] fill_q;
  logic          acc_scan_q, acc_rank_q;

  logic [63:0] rd_time_q;
  logic [3:0]  rd_tag_q;
  logic [31:0] rd_query_q;
  logic        rd_exc_q;

  logic [3:0]    wl_q;
  logic [CW-1:0] n_q, exc_q;
  logic [31:0]   max_q;
  logic [63:0]   cand_t_q, tp50_q, tp95_q;
  logic [31:0]   cand_c_q, qp50_q, qp95_q;
  logic [CW-1:0] lt_t_q, le_t_q, lt_c_q, le_c_q;
  logic          rd_match;

  assign newest   = (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - 1'b1;
  assign rd_addr  = cmd_i.rd_cand ? i_q : j_q;
  assign rd_match = (rd_tag_q == wl_q);

  assign sts_o.fill_zero  = (fill_q == '0);
  assign sts_o.j_last     = (CW'(j_q) + 1'b1 == fill_q);
  assign sts_o.i_last     = (CW'(i_q) + 1'b1 == fill_q);
  assign sts_o.cand_match = rd_match;

  // Rank test without division: value is the nearest-rank pick for pct
  // when lt*100 < n*pct <= le*100.
  function automatic logic rank_hit(input logic [CW-1:0] lt, input logic [CW-1:0] le,
                                    input logic [CW-1:0] n, input logic [6:0] pct);
    logic [MW-1:0] target;
    target = MW'(n) * MW'(pct);
    rank_hit = (MW'(lt) * MW'(PCT_SCALE) < target) && (MW'(le) * MW'(PCT_SCALE) >= target);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      acc_scan_q <= 1'b0;
      acc_rank_q <= 1'b0;
    end else begin
      acc_scan_q <= cmd_i.acc_scan;
      acc_rank_q <= cmd_i.acc_rank;
      if (cmd_i.rec) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q != CW'(DEPTH)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.start || cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.start) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec) begin
      time_mem[wp_q]  <= elapsed_ns_i;
      tag_mem[wp_q]   <= workload_i;
      query_mem[wp_q] <= query_count_i;
      exc_mem[wp_q]   <= budget_exceeded_i;
    end else if (cmd_i.upd) begin
      tag_mem[newest]   <= workload_i;
      query_mem[newest] <= query_count_i;
      exc_mem[newest]   <= budget_exceeded_i;
    end
    rd_time_q  <= time_mem[rd_addr];
    rd_tag_q   <= tag_mem[rd_addr];
    rd_query_q <= query_mem[rd_addr];
    rd_exc_q   <= exc_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wl_q   <= workload_i;
      n_q    <= '0;
      exc_q  <= '0;
      max_q  <= '0;
      tp50_q <= '0;
      tp95_q <= '0;
      qp50_q <= '0;
      qp95_q <= '0;
    end
    if (acc_scan_q && rd_match) begin
      n_q   <= n_q + 1'b1;
      exc_q <= exc_q + CW'(rd_exc_q);
      if (rd_query_q > max_q) max_q <= rd_query_q;
    end
    if (cmd_i.cand_latch) begin
      cand_t_q <= rd_time_q;
      cand_c_q <= rd_query_q;
      lt_t_q   <= '0;
      le_t_q   <= '0;
      lt_c_q   <= '0;
      le_c_q   <= '0;
    end
    if (acc_rank_q && rd_match) begin
      lt_t_q <= lt_t_q + CW'(rd_time_q <  cand_t_q);
      le_t_q <= le_t_q + CW'(rd_time_q <= cand_t_q);
      lt_c_q <= lt_c_q + CW'(rd_query_q <  cand_c_q);
      le_c_q <= le_c_q + CW'(rd_query_q <= cand_c_q);
    end
    if (cmd_i.eval) begin
      if (rank_hit(lt_t_q, le_t_q, n_q, 7'(PCT_MED))) tp50_q <= cand_t_q;
      if (rank_hit(lt_t_q, le_t_q, n_q, 7'(PCT_HI)))  tp95_q <= cand_t_q;
      if (rank_hit(lt_c_q, le_c_q, n_q, 7'(PCT_MED))) qp50_q <= cand_c_q;
      if (rank_hit(lt_c_q, le_c_q, n_q, 7'(PCT_HI)))  qp95_q <= cand_c_q;
    end
    if (cmd_i.load_out) begin
      summary_workload_o <= wl_q;
      match_count_o      <= 7'(n_q);
      time_p50_o         <= tp50_q;
      time_p95_o         <= tp95_q;
      queries_p50_o      <= qp50_q;
      queries_p95_o      <= qp95_q;
      queries_max_o      <= max_q;
      exceeded_total_o   <= 7'(exc_q);
    end
  end

  `LPT_ASSERT_INV(a_fill_bound, clk_i, rst_ni, fill_q <= CW'(DEPTH))
  `LPT_ASSERT_IMP(a_match_bound, clk_i, rst_ni, cmd_i.eval, n_q <= fill_q && n_q != '0)
  `LPT_ASSERT_IMP(a_exc_bound, clk_i, rst_ni, cmd_i.load_out, exc_q <= n_q)

endmodule

// ----- hw/rtl/latency_percentile_telemetry.sv -----
// latency_percentile_telemetry: ring store of DEPTH samples with percentile summaries.
// Record and update requests can arrive back to back while no summary is running.
// Summarize: a scan pass over the filled entries, then a candidate read per filled entry,
// a rank pass and an evaluation per matching entry, and a final load of the result.
// Reset (async, active low) clears the write pointer, fill level and handshake state;
// store contents stay undefined and are only read below the fill level.
`timescale 1ns / 1ps
module latency_percentile_telemetry #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] elapsed_ns_i,
  input  logic [3:0]  workload_i,
  input  logic [31:0] query_count_i,
  input  logic        budget_exceeded_i,
  // summary result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  summary_workload_o,
  output logic [6:0]  match_count_o,
  output logic [63:0] time_p50_o,
  output logic [63:0] time_p95_o,
  output logic [31:0] queries_p50_o,
  output logic [31:0] queries_p95_o,
  output logic [31:0] queries_max_o,
  output logic [6:0]  exceeded_total_o
);
  import lpt_pkg::*;

  // Controller sequences the scan pass (count, max, exceeded) and then a
  // candidate-by-candidate rank pass; the datapath owns the store.
  cmd_t cmd;
  sts_t sts;

  lpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Output registers sit in the datapath, so a pending summary does not
  // block record or update requests.
  lpt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .elapsed_ns_i       (elapsed_ns_i),
    .workload_i         (workload_i),
    .query_count_i      (query_count_i),
    .budget_exceeded_i  (budget_exceeded_i),
    .summary_workload_o (summary_workload_o),
    .match_count_o      (match_count_o),
    .time_p50_o         (time_p50_o),
    .time_p95_o         (time_p95_o),
    .queries_p50_o      (queries_p50_o),
    .queries_p95_o      (queries_p95_o),
    .queries_max_o      (queries_max_o),
    .exceeded_total_o   (exceeded_total_o)
  );

endmodule
